### rtl/core/hsv_color_ratio_detector_macros.svh
`ifndef HSV_COLOR_RATIO_DETECTOR_MACROS_SVH
`define HSV_COLOR_RATIO_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define HCRD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_color_ratio_detector: same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define HCRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_color_ratio_detector: next-cycle check failed");

`endif

### rtl/core/hsvcr_pkg.sv
`timescale 1ns / 1ps
package hsvcr_pkg;

	localparam int unsigned FRAME_W    = 11;
	localparam int unsigned CNT_W      = 19;
	localparam int unsigned RATIO_W    = 16;
	localparam int unsigned PROD_W     = CNT_W + RATIO_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DVD_W      = 18;
	localparam int unsigned DEN_W      = 9;
	localparam int unsigned QUO_W      = DVD_W - DEN_W;
	localparam int unsigned DIV_STEPS  = QUO_W;
	localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [QUO_W-1:0] HUE_WRAP  = QUO_W'(180);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_RATIO_Q16    = 3'd2,
		REG_HUE_MIN      = 3'd3,
		REG_HUE_MAX      = 3'd4,
		REG_SAT_MIN      = 3'd5,
		REG_VAL_MIN      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_pixel;
	} pixel_t;

	typedef struct packed {
		logic             detected;
		logic [CNT_W-1:0] green_count;
		logic [CNT_W-1:0] region_count;
	} result_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
		logic [RATIO_W-1:0] ratio_q16;
		logic [7:0]         hue_min;
		logic [7:0]         hue_max;
		logic [7:0]         sat_min;
		logic [7:0]         val_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		frame_width:  FRAME_W'(640),
		frame_height: FRAME_W'(480),
		ratio_q16:    RATIO_W'(6554),
		hue_min:      8'd35,
		hue_max:      8'd85,
		sat_min:      8'd100,
		val_min:      8'd100
	};

	typedef struct packed {
		logic load_pixel;
		logic prep;
		logic div_start_s;
		logic div_step;
		logic div_start_h;
		logic tally;
		logic product;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_pixel;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/hsvcr_regs.sv
`timescale 1ns / 1ps
module hsvcr_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hsvcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsvcr_pkg::CFG_DATA_W-1:0] cfg_data,
	output hsvcr_pkg::cfg_t                  cfg
);
	import hsvcr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FRAME_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FRAME_W-1:0];
				REG_RATIO_Q16:    cfg_q.ratio_q16    <= cfg_data[RATIO_W-1:0];
				REG_HUE_MIN:      cfg_q.hue_min      <= cfg_data[7:0];
				REG_HUE_MAX:      cfg_q.hue_max      <= cfg_data[7:0];
				REG_SAT_MIN:      cfg_q.sat_min      <= cfg_data[7:0];
				REG_VAL_MIN:      cfg_q.val_min      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/hsvcr_dpath.sv
`timescale 1ns / 1ps
module hsvcr_dpath #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsvcr_pkg::cfg_t    cfg,
	input  hsvcr_pkg::cmd_t    cmd,
	output hsvcr_pkg::sts_t    sts,
	input  hsvcr_pkg::pixel_t  pixel,
	output logic               result_valid,
	input  logic               result_stall,
	output hsvcr_pkg::result_t result
);
	import hsvcr_pkg::*;

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	localparam int unsigned WS_W  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HS_W  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned SZ0_W = (WS_W > HS_W) ? WS_W : HS_W;
	localparam int unsigned SZ_W  = (SZ0_W > FRAME_W) ? SZ0_W : FRAME_W;
	localparam int unsigned RG_W  = SZ_W + 2;
	localparam int unsigned SNUM_W = 17;

	localparam logic [9:0] COEF_R = 10'd361;
	localparam logic [9:0] COEF_G = 10'd481;
	localparam logic [9:0] COEF_B = 10'd601;

	pixel_t pix_q;

	logic [7:0]        v_q;
	logic [7:0]        d_q;
	logic [DVD_W-1:0]  x_q;
	logic [SNUM_W-1:0] snum_q;
	logic [DEN_W-1:0]  sden_q;
	logic [DEN_W-1:0]  hden_q;
	logic [7:0]        s_q;

	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]  green_q;
	logic [CNT_W-1:0]  region_q;
	logic [PROD_W-1:0] prod_q;
	logic              result_valid_q;
	result_t           result_q;

	logic [7:0]        r;
	logic [7:0]        g;
	logic [7:0]        b;
	logic [7:0]        vmax;
	logic [7:0]        vmin;
	logic [7:0]        dlt;
	logic [7:0]        p_ch;
	logic [7:0]        n_ch;
	logic [9:0]        coef;
	logic [DVD_W-1:0]  x_d;
	logic [SNUM_W-1:0] snum_d;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	logic [7:0]        hue;
	logic [7:0]        sat;
	logic              green_px;
	logic [SZ_W-1:0]   fw_ext;
	logic [SZ_W-1:0]   fh_ext;
	logic [SZ_W-1:0]   w_eff;
	logic [SZ_W-1:0]   h_eff;
	logic [RG_W-1:0]   row_inc;
	logic [RG_W-1:0]   row_x3;
	logic              in_region;
	logic              col_wrap;
	logic              row_wrap;
	logic              detected;

	always_comb begin
		r = pix_q.red;
		g = pix_q.green;
		b = pix_q.blue;
		vmax = r;
		vmin = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		dlt = vmax - vmin;
		if (r >= g && r >= b) begin
			p_ch = g;
			n_ch = b;
			coef = COEF_R;
		end else if (g >= b) begin
			p_ch = b;
			n_ch = r;
			coef = COEF_G;
		end else begin
			p_ch = r;
			n_ch = g;
			coef = COEF_B;
		end
		x_d = DVD_W'(p_ch) * DVD_W'(60) + DVD_W'(dlt) * DVD_W'(coef)
			- DVD_W'(n_ch) * DVD_W'(60);
		snum_d = SNUM_W'(dlt) * SNUM_W'(510) + SNUM_W'(vmax);
	end

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_comb begin
		if (d_q == 8'd0) begin
			hue = 8'd0;
		end else if (quo_q >= HUE_WRAP) begin
			hue = 8'(quo_q - HUE_WRAP);
		end else begin
			hue = quo_q[7:0];
		end
		sat = (v_q == 8'd0) ? 8'd0 : s_q;
		green_px = hue >= cfg.hue_min && hue <= cfg.hue_max
			&& sat >= cfg.sat_min && v_q >= cfg.val_min;

		fw_ext = SZ_W'(cfg.frame_width);
		fh_ext = SZ_W'(cfg.frame_height);
		if (fw_ext == '0) begin
			w_eff = SZ_W'(1);
		end else if (fw_ext > SZ_W'(MAX_WIDTH)) begin
			w_eff = SZ_W'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		if (fh_ext == '0) begin
			h_eff = SZ_W'(1);
		end else if (fh_ext > SZ_W'(MAX_HEIGHT)) begin
			h_eff = SZ_W'(MAX_HEIGHT);
		end else begin
			h_eff = fh_ext;
		end

		row_inc   = RG_W'(row_q) + RG_W'(1);
		row_x3    = row_inc + (row_inc << 1);
		in_region = row_x3 <= RG_W'(h_eff);
		col_wrap  = SZ_W'(col_q) + SZ_W'(1) >= w_eff;
		row_wrap  = SZ_W'(row_q) + SZ_W'(1) >= h_eff;
		detected  = {green_q, {RATIO_W{1'b0}}} > prod_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_pixel) begin
			pix_q <= pixel;
		end
		if (cmd.prep) begin
			v_q    <= vmax;
			d_q    <= dlt;
			x_q    <= x_d;
			snum_q <= snum_d;
			sden_q <= {vmax, 1'b0};
			hden_q <= {dlt, 1'b0};
		end
		if (cmd.div_start_s) begin
			rem_q <= DEN_W'(snum_q >> QUO_W);
			quo_q <= snum_q[QUO_W-1:0];
			den_q <= sden_q;
		end else if (cmd.div_start_h) begin
			s_q   <= quo_q[7:0];
			rem_q <= x_q[DVD_W-1:QUO_W];
			quo_q <= x_q[QUO_W-1:0];
			den_q <= hden_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.product) begin
			prod_q <= PROD_W'(region_q) * PROD_W'(cfg.ratio_q16);
		end
		if (cmd.emit) begin
			result_q.detected     <= detected;
			result_q.green_count  <= green_q;
			result_q.region_count <= region_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= '0;
			col_q          <= '0;
			row_q          <= '0;
			green_q        <= '0;
			region_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.div_start_s || cmd.div_start_h) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end

			if (cmd.tally) begin
				if (in_region) begin
					if (region_q != COUNT_MAX) region_q <= region_q + CNT_W'(1);
					if (green_px && green_q != COUNT_MAX) green_q <= green_q + CNT_W'(1);
				end
				if (pix_q.last_pixel) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else if (cmd.emit) begin
				green_q  <= '0;
				region_q <= '0;
			end

			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_done   = step_q == STEP_W'(DIV_STEPS - 1);
	assign sts.last_pixel = pix_q.last_pixel;
	assign sts.out_free   = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/core/hsvcr_ctrl.sv
`timescale 1ns / 1ps
module hsvcr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  hsvcr_pkg::sts_t sts,
	output hsvcr_pkg::cmd_t cmd
);
	import hsvcr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_S_START,
		ST_DIV_S,
		ST_H_START,
		ST_DIV_H,
		ST_TALLY,
		ST_PROD,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_pixel = pixel_valid;
				if (pixel_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_S_START;
			end
			ST_S_START: begin
				cmd.div_start_s = 1'b1;
				state_d         = ST_DIV_S;
			end
			ST_DIV_S: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_H_START;
			end
			ST_H_START: begin
				cmd.div_start_h = 1'b1;
				state_d         = ST_DIV_H;
			end
			ST_DIV_H: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_TALLY;
			end
			ST_TALLY: begin
				cmd.tally = 1'b1;
				state_d   = sts.last_pixel ? ST_PROD : ST_IDLE;
			end
			ST_PROD: begin
				cmd.product = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign pixel_stall = state_q != ST_IDLE;

endmodule

### rtl/core/hsv_color_ratio_detector.sv
// Each pixel taken goes through prep, the S division, the H division and the tally;
// a last pixel then forms the product and puts its result in the output register once
// that register is free. A new pixel waits until the last one is done, paced by the
// single 9-step restoring divider, run once for S and once for H on every pixel.
// Reset (arst_n low, asynchronous): registers take their defaults, position and
// counters clear, the output register empties; no clearing pass follows.
`timescale 1ns / 1ps
module hsv_color_ratio_detector #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  hsvcr_pkg::pixel_t                pixel,
	output logic                             result_valid,
	input  logic                             result_stall,
	output hsvcr_pkg::result_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hsvcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsvcr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hsvcr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	hsvcr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsvcr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	hsvcr_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/core/hsvcr_checker.sv
`timescale 1ns / 1ps
`include "hsv_color_ratio_detector_macros.svh"
module hsvcr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pixel_valid,
	input logic               pixel_stall,
	input logic               result_valid,
	input logic               result_stall,
	input hsvcr_pkg::result_t result
);
	import hsvcr_pkg::*;

	// hold a stalled result transaction
	`HCRD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)
	`HCRD_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))

	// green pixels are a subset of region pixels, saturation included
	`HCRD_ASSERT_SAME(a_green_le_region, result_valid, result.green_count <= result.region_count)

	// an accepted pixel holds pixel_stall high while it occupies the datapath
	`HCRD_ASSERT_NEXT(a_pixel_busy, pixel_valid && !pixel_stall, pixel_stall ##1 pixel_stall)

endmodule

bind hsv_color_ratio_detector hsvcr_checker u_hsvcr_checker (.*);
